// ===== hw/rtl/gpc_pkg.sv =====
package gpc_pkg;

  // Number of gradient stop registers and their layout.
  localparam int N_STOP_WORDS = 7;
  localparam int STOP_WORD_W  = 32;
  localparam int POS_W        = 8;
  localparam int COLOR_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int COUNT_W      = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int INDEX_W      = 8;

  // Configuration register map.
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_WORD0 = 3'd1;

  // Stop count limits.
  localparam logic [COUNT_W-1:0] MIN_STOPS   = 3'd2;
  localparam logic [COUNT_W-1:0] RESET_COUNT = 3'd6;

  // Reset values of the stop words.
  localparam logic [STOP_WORD_W-1:0] RESET_WORDS [N_STOP_WORDS] = '{
    32'h0100_0080, 32'h3300_FFFF, 32'h6600_FF00, 32'h99FF_FF00,
    32'hCCFF_0000, 32'hFF00_0000, 32'h0000_0000
  };

  // Channel scale and the color of index zero.
  localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'hFF;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;

endpackage

// ===== hw/rtl/gradient_palette_color_top.sv =====
// Multi-stop linear color gradient lookup.
// Input channel: in_valid / in_stall with palette_index. An item is taken
// when in_valid is high and in_stall is low; in_stall stays high while an
// item is being worked on.
// Output channel: out_valid / out_stall with rgb_color and entry_index.
// The result sits in an output register and holds while out_stall is high;
// the next item is accepted even while that result waits.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data.
// Index 0 sets the stop count, indexes 1 to 7 set stop words 0 to 6.
// cfg_ready is always high; write only while the block is idle.
// Sequence: index zero goes straight to black. Any other index goes through
// segment search, a load of the stops, one divide for the segment fraction
// (skipped when the segment length is not positive), three channel passes
// around a divide by 255 on a single shared radix-4 divider, and a load of
// the output register. One item is worked on at a time; the next is taken
// once the block is back in idle.
// If the receiver stalls, the finished result waits in the output register
// and the block holds its next result until the register is free.
// Reset (rst, synchronous) clears the handshakes and restores the defaults.
module gradient_palette_color_top
  import gpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [INDEX_W-1:0]     palette_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COLOR_W-1:0]     rgb_color,
  output logic [INDEX_W-1:0]     entry_index,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [STOP_WORD_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_LOAD, S_SETUP, S_TDIV, S_MUL, S_CDIV, S_CADD, S_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0] rem;
    logic       q;
  } div_step_t;

  localparam logic [3:0] TDIV_LAST = 4'd7;
  localparam logic [3:0] CDIV_LAST = 4'd11;

  // One restoring division step: shift in one dividend bit, subtract if it fits.
  function automatic div_step_t div_step(input logic [7:0] rem, input logic bit_in,
                                         input logic [7:0] den);
    logic [8:0] r9;
    div_step_t  res;
    r9 = {rem, bit_in};
    if (r9 >= {1'b0, den}) begin
      res.rem = 8'(r9 - {1'b0, den});
      res.q   = 1'b1;
    end else begin
      res.rem = r9[7:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

  state_t                 state;
  logic [STOP_WORD_W-1:0] stop_word [N_STOP_WORDS];
  logic [COUNT_W-1:0]     stop_count;
  logic [INDEX_W-1:0]     idx;
  logic [2:0]             seg;
  logic [STOP_WORD_W-1:0] start_word;
  logic [STOP_WORD_W-1:0] end_word;
  logic [15:0]            t_mag;
  logic                   t_neg;
  logic                   q_neg;
  logic [1:0]             ch;
  logic [COLOR_W-1:0]     rgb_acc;
  logic [7:0]             div_rem;
  logic [23:0]            div_quo;
  logic [7:0]             div_den;
  logic [3:0]             div_cnt;

  logic [COUNT_W-1:0]     n_used;
  logic [2:0]             rd_addr;
  logic [STOP_WORD_W-1:0] rd_word;
  logic                   seg_more;
  logic signed [8:0]      num;
  logic signed [8:0]      len;
  logic [7:0]             num_mag;
  logic [15:0]            t_dividend;
  logic [4:0]             ch_lsb;
  logic [CHAN_W-1:0]      c0;
  logic [CHAN_W-1:0]      c1;
  logic signed [8:0]      diff;
  logic [7:0]             diff_mag;
  logic [23:0]            product;
  logic signed [17:0]     chan_sum;
  logic [CHAN_W-1:0]      chan_sat;
  div_step_t              step_a;
  div_step_t              step_b;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= RESET_COUNT;
      for (int k = 0; k < N_STOP_WORDS; k++) begin
        stop_word[k] <= RESET_WORDS[k];
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_STOP_COUNT) begin
        stop_count <= cfg_data[COUNT_W-1:0];
      end else begin
        stop_word[3'(cfg_index - CFG_STOP_WORD0)] <= cfg_data;
      end
    end
  end

  // Stop count clamped to at least two; three bits never exceed seven.
  assign n_used = (stop_count < MIN_STOPS) ? MIN_STOPS : stop_count;

  // Single read port on the stop words: next end stop while searching,
  // start stop otherwise.
  assign rd_addr  = (state == S_SEARCH) ? 3'(seg + 3'd1) : seg;
  assign rd_word  = stop_word[rd_addr];
  assign seg_more = ({1'b0, seg} + 4'd2 < {1'b0, n_used}) &&
                    (idx > rd_word[STOP_WORD_W-1 -: POS_W]);

  // Segment offset and length, and the scaled fraction dividend.
  assign num        = $signed({1'b0, idx}) -
                      $signed({1'b0, start_word[STOP_WORD_W-1 -: POS_W]});
  assign len        = $signed({1'b0, end_word[STOP_WORD_W-1 -: POS_W]}) -
                      $signed({1'b0, start_word[STOP_WORD_W-1 -: POS_W]});
  assign num_mag    = num[8] ? 8'(-num) : num[7:0];
  assign t_dividend = {num_mag, 8'h00} - {8'h00, num_mag};

  // Channel operands and the blend product.
  assign ch_lsb   = {ch, 3'b000};
  assign c0       = start_word[ch_lsb +: CHAN_W];
  assign c1       = end_word[ch_lsb +: CHAN_W];
  assign diff     = $signed({1'b0, c1}) - $signed({1'b0, c0});
  assign diff_mag = diff[8] ? 8'(-diff) : diff[7:0];
  assign product  = {16'h0000, diff_mag} * {8'h00, t_mag};

  // Add the signed quotient to the start channel and saturate.
  always_comb begin
    if (q_neg) begin
      chan_sum = $signed({10'h000, c0}) - $signed({2'b00, div_quo[15:0]});
    end else begin
      chan_sum = $signed({10'h000, c0}) + $signed({2'b00, div_quo[15:0]});
    end
    if (chan_sum < 0) begin
      chan_sat = '0;
    end else if (chan_sum > $signed({10'h000, CHAN_MAX})) begin
      chan_sat = CHAN_MAX;
    end else begin
      chan_sat = chan_sum[7:0];
    end
  end

  // Shared divider: two quotient bits per cycle.
  always_comb begin
    step_a = div_step(div_rem, div_quo[23], div_den);
    step_b = div_step(step_a.rem, div_quo[22], div_den);
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new result replaces the old one as it leaves, or fills an empty register.
      if (state == S_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            idx     <= palette_index;
            seg     <= '0;
            rgb_acc <= COLOR_BLACK;
            state   <= (palette_index == '0) ? S_FINISH : S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (seg_more) begin
            seg <= 3'(seg + 3'd1);
          end else begin
            end_word <= rd_word;
            state    <= S_LOAD;
          end
        end
        S_LOAD: begin
          start_word <= rd_word;
          state      <= S_SETUP;
        end
        S_SETUP: begin
          ch <= 2'd2;
          if (len > 0) begin
            t_neg   <= num[8];
            div_rem <= '0;
            div_quo <= {t_dividend, 8'h00};
            div_den <= len[7:0];
            div_cnt <= TDIV_LAST;
            state   <= S_TDIV;
          end else begin
            t_mag <= '0;
            t_neg <= 1'b0;
            state <= S_MUL;
          end
        end
        S_TDIV, S_CDIV: begin
          div_rem <= step_b.rem;
          div_quo <= {div_quo[21:0], step_a.q, step_b.q};
          div_cnt <= 4'(div_cnt - 4'd1);
          if (div_cnt == '0) begin
            if (state == S_TDIV) begin
              t_mag <= {div_quo[13:0], step_a.q, step_b.q};
              state <= S_MUL;
            end else begin
              state <= S_CADD;
            end
          end
        end
        S_MUL: begin
          q_neg   <= diff[8] ^ t_neg;
          div_rem <= '0;
          div_quo <= product;
          div_den <= CHAN_MAX;
          div_cnt <= CDIV_LAST;
          state   <= S_CDIV;
        end
        S_CADD: begin
          rgb_acc[ch_lsb +: CHAN_W] <= chan_sat;
          if (ch == '0) begin
            state <= S_FINISH;
          end else begin
            ch    <= 2'(ch - 2'd1);
            state <= S_MUL;
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            rgb_color   <= rgb_acc;
            entry_index <= idx;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/gpc_checker.sv =====
module gpc_checker
  import gpc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [COLOR_W-1:0]     rgb_color,
  input logic [INDEX_W-1:0]     entry_index
);

  // The block turns busy once it takes an item.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an item was accepted");

  // No result appears in the cycle right after an item is taken.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A new result is only presented as the block returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result presented while still busy");

  // Index zero always maps to black.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_index == '0) |-> (rgb_color == COLOR_BLACK))
    else $error("index zero is not black");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(rgb_color) && $stable(entry_index)))
    else $error("stalled result changed");

endmodule

bind gradient_palette_color_top gpc_checker u_gpc_checker (.*);

// ===== bench/tb_gradient_palette_color_top.sv =====
`timescale 1ns / 1ps

module tb_gradient_palette_color_top;
  import gpc_pkg::*;

  localparam int CHAN_SCALE  = CHAN_MAX;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 50;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 8;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  // One line of the directed script: a register write or a lookup.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [STOP_WORD_W-1:0] wdata;
    logic [INDEX_W-1:0]     idx;
    logic                   pinned;
    logic [COLOR_W-1:0]     rgb;
  } script_row_t;

  // A palette entry the block owes us.
  typedef struct packed {
    logic [COLOR_W-1:0] rgb;
    logic [INDEX_W-1:0] idx;
  } palette_entry_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [INDEX_W-1:0]     palette_index;
  logic                   out_valid;
  logic                   out_stall;
  logic [COLOR_W-1:0]     rgb_color;
  logic [INDEX_W-1:0]     entry_index;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [STOP_WORD_W-1:0] cfg_data;

  // Our own copy of the gradient registers.
  logic [COUNT_W-1:0]     stop_count_q;
  logic [STOP_WORD_W-1:0] stop_words_q [N_STOP_WORDS];

  palette_entry_t owed_entries [$];
  script_row_t    script [$];

  logic               pin_on;
  logic [COLOR_W-1:0] pin_rgb;
  bit                 in_idle_on;
  bit                 out_idle_on;
  int                 hold_request;
  int                 error_count;
  int                 items_sent;
  int                 entries_checked;
  int                 reg_writes;

  gradient_palette_color_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .palette_index (palette_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .rgb_color     (rgb_color),
    .entry_index   (entry_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit on the whole run.
  initial begin
    #5_000_000;
    $display("[gradient_palette_color_top] ERROR");
    $finish;
  end

  // Color of one palette entry under the current stop settings.
  function automatic logic [COLOR_W-1:0] gradient_rgb(input logic [INDEX_W-1:0] idx);
    int n, i, seg, start, len, t, c0, c1, c;
    logic [COLOR_W-1:0] ca, cb, rgb;
    n = int'(stop_count_q);
    if (n < int'(MIN_STOPS)) n = int'(MIN_STOPS);
    if (n > N_STOP_WORDS) n = N_STOP_WORDS;
    if (idx == '0) return COLOR_BLACK;
    i = int'(idx);
    seg = 0;
    // First segment whose end covers the index, else the last one.
    while (seg + 2 < n && i > int'(stop_words_q[seg+1][STOP_WORD_W-1 -: POS_W])) seg++;
    start = int'(stop_words_q[seg][STOP_WORD_W-1 -: POS_W]);
    len = int'(stop_words_q[seg+1][STOP_WORD_W-1 -: POS_W]) - start;
    t = (len > 0) ? ((i - start) * CHAN_SCALE) / len : 0;
    ca = stop_words_q[seg][COLOR_W-1:0];
    cb = stop_words_q[seg+1][COLOR_W-1:0];
    // Blend each channel; t may lie outside 0..255, so clamp.
    for (int ch = 0; ch < 3; ch++) begin
      c0 = int'(ca[ch*CHAN_W +: CHAN_W]);
      c1 = int'(cb[ch*CHAN_W +: CHAN_W]);
      c = c0 + ((c1 - c0) * t) / CHAN_SCALE;
      if (c < 0) c = 0;
      if (c > CHAN_SCALE) c = CHAN_SCALE;
      rgb[ch*CHAN_W +: CHAN_W] = c[CHAN_W-1:0];
    end
    return rgb;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] reg_idx,
                           input logic [STOP_WORD_W-1:0] wdata);
    script.push_back('{ROW_WRITE, reg_idx, wdata, '0, 1'b0, '0});
  endtask

  task automatic add_item(input logic [INDEX_W-1:0] idx, input logic pinned,
                          input logic [COLOR_W-1:0] rgb);
    script.push_back('{ROW_ITEM, '0, '0, idx, pinned, rgb});
  endtask

  // Offer one item, with a random gap first, and wait until it is taken.
  task automatic send_index(input logic [INDEX_W-1:0] idx, input logic pinned,
                            input logic [COLOR_W-1:0] rgb);
    int gap;
    gap = (in_idle_on && $urandom_range(99) < 29) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    palette_index <= idx;
    pin_on        <= pinned;
    pin_rgb       <= rgb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every owed entry has come back.
  task automatic drain_entries();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_entries.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // One register write; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx,
                           input logic [STOP_WORD_W-1:0] wdata);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data  <= wdata;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      out_stall <= 1'b1;
      hold_request <= hold_request - 1;
    end else begin
      out_stall <= out_idle_on && ($urandom_range(99) < 29);
    end
  end

  // Track register writes, record owed entries and check returned ones.
  always @(posedge clk) begin
    palette_entry_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STOP_COUNT) stop_count_q = cfg_data[COUNT_W-1:0];
        else stop_words_q[cfg_index - CFG_STOP_WORD0] = cfg_data;
        reg_writes++;
      end
      if (in_valid && !in_stall) begin
        want.rgb = pin_on ? pin_rgb : gradient_rgb(palette_index);
        want.idx = palette_index;
        owed_entries.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (owed_entries.size() == 0) begin
          report_mismatch($sformatf("unexpected entry %0d color %06h", entry_index, rgb_color));
        end else begin
          want = owed_entries.pop_front();
          entries_checked++;
          if (entry_index !== want.idx)
            report_mismatch($sformatf("entry_index %0d, want %0d", entry_index, want.idx));
          if (rgb_color !== want.rgb)
            report_mismatch($sformatf("entry %0d rgb_color %06h, want %06h",
                                      want.idx, rgb_color, want.rgb));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    logic [STOP_WORD_W-1:0] word;
    logic [INDEX_W-1:0]     idx;
    int                     pos, pick, k;
    bit                     sorted;
    logic [COUNT_W-1:0]     phase_counts [NUM_PHASES];

    phase_counts = '{3'd2, 3'd7, 3'd0, 3'd1, 3'd3, 3'd4, 3'd5, 3'd6};
    rst           = 1'b1;
    in_valid      = 1'b0;
    palette_index = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    pin_on        = 1'b0;
    pin_rgb       = '0;
    in_idle_on    = 1'b1;
    out_idle_on   = 1'b1;
    hold_request  = 0;
    error_count   = 0;
    items_sent    = 0;
    entries_checked = 0;
    reg_writes    = 0;
    stop_count_q  = RESET_COUNT;
    foreach (stop_words_q[j]) stop_words_q[j] = RESET_WORDS[j];

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset gradient: zero is black, each stop position lands on its color.
    add_item(8'd0,   1'b1, 24'h000000);
    add_item(8'd1,   1'b1, 24'h000080);
    add_item(8'd51,  1'b1, 24'h00FFFF);
    add_item(8'd102, 1'b1, 24'h00FF00);
    add_item(8'd153, 1'b1, 24'hFFFF00);
    add_item(8'd204, 1'b1, 24'hFF0000);
    add_item(8'd255, 1'b1, 24'h000000);
    add_item(8'd128, 1'b0, '0);
    // A stop count of zero acts as two: white at 0 fading to black at 255.
    add_write(CFG_STOP_COUNT, 32'h0000_0000);
    add_write(CFG_STOP_WORD0, 32'h00FF_FFFF);
    add_write(CFG_STOP_WORD0 + 3'd1, 32'hFF00_0000);
    add_item(8'd255, 1'b1, 24'h000000);
    add_item(8'd1,   1'b1, 24'hFEFEFE);
    add_item(8'd0,   1'b1, 24'h000000);
    add_item(8'd128, 1'b0, '0);
    // A stop count of one acts as two; equal positions give the start color.
    add_write(CFG_STOP_COUNT, 32'h0000_0001);
    add_write(CFG_STOP_WORD0, 32'h80FF_FFFF);
    add_write(CFG_STOP_WORD0 + 3'd1, 32'h8000_0000);
    add_item(8'd200, 1'b1, 24'hFFFFFF);
    add_item(8'd1,   1'b1, 24'hFFFFFF);
    // A one-step segment drives t far out of range in both directions.
    add_write(CFG_STOP_COUNT, 32'hFFFF_FFFA);
    add_write(CFG_STOP_WORD0, 32'h8000_FF80);
    add_write(CFG_STOP_WORD0 + 3'd1, 32'h81FF_0080);
    add_item(8'd1,   1'b1, 24'h00FF80);
    add_item(8'd255, 1'b1, 24'hFF0080);
    // All seven stops, with a flat and a falling segment in the middle.
    add_write(CFG_STOP_COUNT, 32'hFFFF_FFFF);
    add_write(CFG_STOP_WORD0,        32'h1012_3456);
    add_write(CFG_STOP_WORD0 + 3'd1, 32'h30AB_CDEF);
    add_write(CFG_STOP_WORD0 + 3'd2, 32'h3000_FF00);
    add_write(CFG_STOP_WORD0 + 3'd3, 32'h20FF_00FF);
    add_write(CFG_STOP_WORD0 + 3'd4, 32'hE080_8080);
    add_write(CFG_STOP_WORD0 + 3'd5, 32'hF000_00FF);
    add_write(CFG_STOP_WORD0 + 3'd6, 32'hFFFF_FFFF);
    add_item(8'h01, 1'b0, '0);
    add_item(8'h20, 1'b0, '0);
    add_item(8'h30, 1'b0, '0);
    add_item(8'h31, 1'b0, '0);
    add_item(8'hF8, 1'b0, '0);
    add_item(8'hFF, 1'b0, '0);

    // Walk the script; registers are only touched once the block is idle.
    foreach (script[r]) begin
      if (script[r].kind == ROW_WRITE) begin
        if (r == 0 || script[r-1].kind == ROW_ITEM) drain_entries();
        write_reg(script[r].reg_idx, script[r].wdata);
      end else begin
        send_index(script[r].idx, script[r].pinned, script[r].rgb);
      end
    end
    drain_entries();

    // Random phases, each under a fresh gradient setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      sorted = ($urandom_range(99) < 70);
      pos = $urandom_range(0, 40);
      write_reg(CFG_STOP_COUNT, ($urandom & ~32'h7) | phase_counts[ph]);
      for (k = 0; k < N_STOP_WORDS; k++) begin
        if (ph == 2) word = 32'h0000_0000;
        else if (ph == 3) word = 32'hFFFF_FFFF;
        else if (sorted) word = {pos[POS_W-1:0], 24'($urandom)};
        else word = $urandom;
        write_reg(CFG_STOP_WORD0 + 3'(k), word);
        pos = pos + $urandom_range(0, 70);
        if (pos > 255) pos = 255;
      end

      in_idle_on  = (ph != 5);
      out_idle_on = (ph != 5);
      if (ph == 4) hold_request = HOLD_CYCLES;
      pin_on = 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Indexes near a stop position, some zero, and most often anywhere.
        pick = $urandom_range(99);
        if (pick < 8) begin
          idx = '0;
        end else if (pick < 45) begin
          k = $urandom_range(0, N_STOP_WORDS - 1);
          pos = int'(stop_words_q[k][STOP_WORD_W-1 -: POS_W]) + $urandom_range(0, 4) - 2;
          if (pos < 0) pos = 0;
          if (pos > 255) pos = 255;
          idx = pos[INDEX_W-1:0];
        end else begin
          idx = INDEX_W'($urandom_range(0, 255));
        end
        send_index(idx, 1'b0, '0);
        if (ph == 6 && n == PHASE_ITEMS / 2) drain_entries();
      end
      drain_entries();
    end

    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (4 * SETTLE) @(posedge clk);

    $display("Looked up %0d palette entries and compared %0d of them;", items_sent,
             entries_checked);
    $display("%0d register writes over the reset gradient and %0d random settings.",
             reg_writes, NUM_PHASES);
    if (error_count == 0 && owed_entries.size() == 0) begin
      $display("[gradient_palette_color_top] OK");
    end else begin
      $display("[gradient_palette_color_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== gradient_palette_color_top.f =====
hw/rtl/gpc_pkg.sv
hw/rtl/gradient_palette_color_top.sv
hw/rtl/gpc_checker.sv
bench/tb_gradient_palette_color_top.sv
